// ===== rtl/pbba_pkg.sv =====
// ----------------------------------------------------------------------------
// pbba_pkg
// Shared types, codes and saturating arithmetic for the primitive bounding
// box accumulator.
// ----------------------------------------------------------------------------
package pbba_pkg;

	localparam int COORD_W   = 32;
	localparam int MODE_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int NUM_AXES  = 3;

	typedef logic signed [COORD_W-1:0] coord_t;

	// Primitive modes; codes 14 and 15 are undefined and leave the box alone
	typedef enum logic [MODE_W-1:0] {
		MODE_POINT           = 4'd0,
		MODE_RECT_XY         = 4'd1,
		MODE_RECT_XZ         = 4'd2,
		MODE_RECT_YZ         = 4'd3,
		MODE_RECT_XY_FIXDIM  = 4'd4,
		MODE_PIN_XY          = 4'd5,
		MODE_PIN_XZ          = 4'd6,
		MODE_PIN_YZ          = 4'd7,
		MODE_PIN_XY_FIXDIM   = 4'd8,
		MODE_PIN_XZ_FIXDIM   = 4'd9,
		MODE_PIN_YZ_FIXDIM   = 4'd10,
		MODE_LINE_XY         = 4'd11,
		MODE_LINE_XZ         = 4'd12,
		MODE_HEXAGON         = 4'd13
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE    = 2'd0,
		REG_DCOORD  = 2'd1,
		REG_DWIDTH  = 2'd2,
		REG_DHEIGHT = 2'd3
	} reg_idx_t;

	localparam coord_t DWIDTH_RESET  = coord_t'(65536);
	localparam coord_t DHEIGHT_RESET = coord_t'(65536);

	// Per-axis update: upd folds [lo, hi] in, pin overwrites both bounds
	typedef struct packed {
		logic   upd;
		logic   pin;
		coord_t lo;
		coord_t hi;
	} axis_cmd_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	function automatic coord_t sat_add(coord_t p, coord_t q);
		logic signed [COORD_W:0] s;
		s = {p[COORD_W-1], p} + {q[COORD_W-1], q};
		if (s[COORD_W] != s[COORD_W-1])
			return s[COORD_W] ? COORD_MIN : COORD_MAX;
		return s[COORD_W-1:0];
	endfunction

	function automatic coord_t sat_sub(coord_t p, coord_t q);
		logic signed [COORD_W:0] s;
		s = {p[COORD_W-1], p} - {q[COORD_W-1], q};
		if (s[COORD_W] != s[COORD_W-1])
			return s[COORD_W] ? COORD_MIN : COORD_MAX;
		return s[COORD_W-1:0];
	endfunction

endpackage

// ===== rtl/primitive_bounding_box_accumulator.sv =====
// ----------------------------------------------------------------------------
// primitive_bounding_box_accumulator
// Running axis-aligned 3D bounding box over a stream of planar primitives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one primitive per item:
//   start_new, and coord_a..coord_c, extent_w, extent_h in signed Q16.16.
//   Output channel (out_valid/out_ready) returns the running box
//   (min/max for x, y, z) after every item, exactly one result per item.
//   Configuration (cfg_wr_en, cfg_index, cfg_data) sets the primitive
//   mode and the default coordinate, width and height; write it only
//   while no item is in flight.
//   Path: an accepted item lands in the input register, its box is then
//   loaded into the result register and is offered on the output from there.
//   Throughput: one item per cycle while results are taken. The input
//   register and the box register each hold one item, so a new item is
//   accepted while a result waits; the fold of one item into the box is a
//   saturating add and a compare per bound, done in the single stage between the two.
//   Receiver stall: the result holds, the box waits, and in_ready drops
//   once the input register also holds an item.
//   Reset: the box clears to zero, no item counts as seen, mode returns
//   to rectangle XY, default width and height to 1.0.
// ----------------------------------------------------------------------------
module primitive_bounding_box_accumulator import pbba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	// input items
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 start_new,
	input  coord_t               coord_a,
	input  coord_t               coord_b,
	input  coord_t               coord_c,
	input  coord_t               extent_w,
	input  coord_t               extent_h,
	// result items
	output logic                 out_valid,
	input  logic                 out_ready,
	output coord_t               min_x,
	output coord_t               max_x,
	output coord_t               min_y,
	output coord_t               max_y,
	output coord_t               min_z,
	output coord_t               max_z
);

	// configuration registers
	mode_t  mode_q;
	coord_t dcoord_q;
	coord_t dwidth_q;
	coord_t dheight_q;

	// input register
	logic   valid_s1;
	logic   start_new_s1;
	coord_t a_s1;
	coord_t b_s1;
	coord_t c_s1;
	coord_t w_s1;
	coord_t h_s1;

	// running box, also the result register
	coord_t box_q [2*NUM_AXES];
	coord_t box_nxt [2*NUM_AXES];
	logic   started_q;

	axis_cmd_t [NUM_AXES-1:0] cmd;
	logic   known;
	logic   adv_s1;
	logic   fresh;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RECT_XY;
			dcoord_q  <= '0;
			dwidth_q  <= DWIDTH_RESET;
			dheight_q <= DHEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:    mode_q    <= mode_t'(cfg_data[MODE_W-1:0]);
				REG_DCOORD:  dcoord_q  <= cfg_data;
				REG_DWIDTH:  dwidth_q  <= cfg_data;
				REG_DHEIGHT: dheight_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the input register when the result register is free or drains
	assign adv_s1   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload needs no reset; load only on accept
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			start_new_s1 <= start_new;
			a_s1         <= coord_a;
			b_s1         <= coord_b;
			c_s1         <= coord_c;
			w_s1         <= extent_w;
			h_s1         <= extent_h;
		end
	end

	pbba_decode u_decode (
		.mode    (mode_q),
		.dcoord  (dcoord_q),
		.dwidth  (dwidth_q),
		.dheight (dheight_q),
		.a       (a_s1),
		.b       (b_s1),
		.c       (c_s1),
		.w       (w_s1),
		.h       (h_s1),
		.cmd     (cmd),
		.known   (known)
	);

	// First item of a box replaces the bounds instead of merging
	assign fresh = !started_q || start_new_s1;

	// Fold each axis: the lower end only moves the min, the upper end the max;
	// a pinned axis is overwritten
	always_comb begin
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			box_nxt[2*ax]   = box_q[2*ax];
			box_nxt[2*ax+1] = box_q[2*ax+1];
			if (cmd[ax].upd) begin
				if (fresh || cmd[ax].pin || (cmd[ax].lo < box_q[2*ax]))
					box_nxt[2*ax] = cmd[ax].lo;
				if (fresh || cmd[ax].pin || (cmd[ax].hi > box_q[2*ax+1]))
					box_nxt[2*ax+1] = cmd[ax].hi;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			started_q <= 1'b0;
			for (int i = 0; i < 2*NUM_AXES; i++)
				box_q[i] <= '0;
		end else begin
			if (adv_s1) begin
				out_valid <= 1'b1;
				// an undefined mode leaves the box and the seen flag alone
				started_q <= started_q | known;
				for (int i = 0; i < 2*NUM_AXES; i++)
					box_q[i] <= box_nxt[i];
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Hold the box on the outputs until the next item folds in
	assign min_x = box_q[0];
	assign max_x = box_q[1];
	assign min_y = box_q[2];
	assign max_y = box_q[3];
	assign min_z = box_q[4];
	assign max_z = box_q[5];

	// The box only changes when an item moves out of the input register
	a_box_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> ($stable(min_x) && $stable(max_x) && $stable(min_y) &&
		             $stable(max_y) && $stable(min_z) && $stable(max_z)))
		else $error("box changed without an item advancing");

	// A pinned axis collapses to a single coordinate
	a_pin_x: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cmd[0].pin) |=> (min_x == max_x))
		else $error("pinned x axis not collapsed");

	a_pin_y: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cmd[1].pin) |=> (min_y == max_y))
		else $error("pinned y axis not collapsed");

	a_pin_z: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cmd[2].pin) |=> (min_z == max_z))
		else $error("pinned z axis not collapsed");

	// Backpressure reaches the input only when both registers are full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("input stalled with room in the pipeline");

endmodule

// ===== rtl/pbba_decode.sv =====
// ----------------------------------------------------------------------------
// pbba_decode
// Maps one primitive onto per-axis spans according to the primitive mode.
// ----------------------------------------------------------------------------
module pbba_decode import pbba_pkg::*; (
	input  mode_t                      mode,
	input  coord_t                     dcoord,
	input  coord_t                     dwidth,
	input  coord_t                     dheight,
	input  coord_t                     a,
	input  coord_t                     b,
	input  coord_t                     c,
	input  coord_t                     w,
	input  coord_t                     h,
	output axis_cmd_t [NUM_AXES-1:0]   cmd,
	output logic                       known
);

	coord_t w_eff;
	coord_t h_eff;
	coord_t a_hi;
	coord_t b_hi;
	coord_t a_lo_r;
	coord_t b_lo_r;
	coord_t b_hi_r;
	logic   fixdim;

	function automatic axis_cmd_t span(coord_t lo, coord_t hi);
		axis_cmd_t r;
		r.upd = 1'b1;
		r.pin = 1'b0;
		r.lo  = lo;
		r.hi  = hi;
		return r;
	endfunction

	// both endpoints go against both bounds
	function automatic axis_cmd_t pair(coord_t p, coord_t q);
		axis_cmd_t r;
		r.upd = 1'b1;
		r.pin = 1'b0;
		r.lo  = (p < q) ? p : q;
		r.hi  = (p < q) ? q : p;
		return r;
	endfunction

	function automatic axis_cmd_t pinned(coord_t v);
		axis_cmd_t r;
		r.upd = 1'b1;
		r.pin = 1'b1;
		r.lo  = v;
		r.hi  = v;
		return r;
	endfunction

	assign fixdim = (mode == MODE_RECT_XY_FIXDIM) || (mode == MODE_PIN_XY_FIXDIM) ||
	                (mode == MODE_PIN_XZ_FIXDIM) || (mode == MODE_PIN_YZ_FIXDIM);
	assign w_eff  = fixdim ? dwidth : w;
	assign h_eff  = fixdim ? dheight : h;
	assign a_hi   = sat_add(a, w_eff);
	assign b_hi   = sat_add(b, h_eff);
	// hexagon square edges, radius taken from the item
	assign a_lo_r = sat_sub(a, w);
	assign b_lo_r = sat_sub(b, w);
	assign b_hi_r = sat_add(b, w);

	always_comb begin
		cmd   = '0;
		known = 1'b1;
		case (mode)
			MODE_POINT: begin
				cmd[0] = span(a, a);
				cmd[1] = span(b, b);
				cmd[2] = span(c, c);
			end
			MODE_RECT_XY, MODE_RECT_XY_FIXDIM: begin
				cmd[0] = span(a, a_hi);
				cmd[1] = span(b, b_hi);
				cmd[2] = span(c, c);
			end
			MODE_RECT_XZ: begin
				cmd[0] = span(a, a_hi);
				cmd[2] = span(b, b_hi);
				cmd[1] = span(c, c);
			end
			MODE_RECT_YZ: begin
				cmd[1] = span(a, a_hi);
				cmd[2] = span(b, b_hi);
				cmd[0] = span(c, c);
			end
			MODE_PIN_XY, MODE_PIN_XY_FIXDIM: begin
				cmd[0] = span(a, a_hi);
				cmd[1] = span(b, b_hi);
				cmd[2] = pinned(dcoord);
			end
			MODE_PIN_XZ, MODE_PIN_XZ_FIXDIM: begin
				cmd[0] = span(a, a_hi);
				cmd[2] = span(b, b_hi);
				cmd[1] = pinned(dcoord);
			end
			MODE_PIN_YZ, MODE_PIN_YZ_FIXDIM: begin
				cmd[1] = span(a, a_hi);
				cmd[2] = span(b, b_hi);
				cmd[0] = pinned(dcoord);
			end
			MODE_LINE_XY: begin
				cmd[0] = pair(a, a_hi);
				cmd[1] = pair(b, b_hi);
				cmd[2] = span(dcoord, dcoord);
			end
			MODE_LINE_XZ: begin
				cmd[0] = pair(a, a_hi);
				cmd[2] = pair(b, b_hi);
				cmd[1] = span(dcoord, dcoord);
			end
			MODE_HEXAGON: begin
				cmd[0] = pair(a_lo_r, a_hi);
				cmd[1] = pair(b_lo_r, b_hi_r);
				cmd[2] = span(c, c);
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

endmodule
